>>> design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, constants and the digit character function for the itoa block
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned BASE_W     = 5;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAX_DIGITS = 32;
    localparam int unsigned STACK_W    = MAX_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CHUNK_W    = 8;
    localparam int unsigned CHUNKS     = VALUE_W / CHUNK_W;
    localparam int unsigned CHUNK_IDX_W = $clog2(CHUNKS);
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
        logic emit_nul;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_chunk;
        logic quot_zero;
        logic neg;
        logic one_left;
        logic out_free;
    } t_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

>>> design/integer_to_ascii_any_base_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_any_base_top
// formats a signed 32-bit value as ascii text in a radix from 2 to 16
// ----------------------------------------------------------------------------
// One value comes in per slave beat and leaves as a run of character beats,
// most significant first: a '-' for negative values, the digits ('0'-'9',
// 'A'-'F'), then a nul beat with tlast set that carries the character count
// (without the nul). The radix register resets to 10 and is written through
// the cfg channel; written values below 2 or above 16 clamp to 2 and 16.
// Write it only while no run is in progress. One value is in flight at a
// time. The division unit works 8 bits of the 32-bit magnitude per cycle,
// one digit per pass over the four bytes, so a value with D digits takes
// an accept, D division passes, then D+1 output beats (D+2 when negative),
// one per cycle while the sink keeps tready high.
// ----------------------------------------------------------------------------
module integer_to_ascii_any_base_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // radix write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,     // number_base
    // value in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    // characters out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_out, [13:8] char_count, [15:14] zero
    output logic        m_axis_tlast    // is_last, set on the nul beat
);

    itoa_pkg::t_cmd    w_cmd;
    itoa_pkg::t_status w_sts;
    logic [itoa_pkg::CHAR_W-1:0] w_char;
    logic [itoa_pkg::CNT_W-1:0]  w_count;

    // radix writes are always taken
    assign o_cfg_ready = 1'b1;

    itoa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_value     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_char      (w_char),
        .o_last      (m_axis_tlast),
        .o_count     (w_count)
    );

    // pack character and count, pad to whole bytes
    assign m_axis_tdata = {2'b00, w_count, w_char};

endmodule

>>> design/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer: accept, divide digit by digit, then emit sign, digits and nul
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  itoa_pkg::t_status   i_sts,
    output itoa_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SIGN  = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_NUL   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.last_chunk && i_sts.quot_zero) begin
                    n_state = i_sts.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.one_left) begin
                        n_state = ST_NUL;
                    end
                end
            end
            ST_NUL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_nul = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// base register, chunked long division, digit stack and output register
// ----------------------------------------------------------------------------
module itoa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [itoa_pkg::BASE_W-1:0]         i_cfg_data,
    input  logic [itoa_pkg::VALUE_W-1:0]        i_value,
    input  itoa_pkg::t_cmd                      i_cmd,
    output itoa_pkg::t_status                   o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [itoa_pkg::CHAR_W-1:0]         o_char,
    output logic                                o_last,
    output logic [itoa_pkg::CNT_W-1:0]          o_count
);

    logic [itoa_pkg::BASE_W-1:0]      r_base;
    logic [itoa_pkg::VALUE_W-1:0]     r_work;
    logic [itoa_pkg::DIGIT_W-1:0]     r_rem;
    logic [itoa_pkg::CHUNK_IDX_W-1:0] r_chunk;
    logic                             r_neg;
    logic [itoa_pkg::STACK_W-1:0]     r_stack;
    logic [itoa_pkg::CNT_W-1:0]       r_ndig;
    logic [itoa_pkg::CNT_W-1:0]       r_nchar;
    logic                             r_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]      r_out_char;
    logic                             r_out_last;
    logic [itoa_pkg::CNT_W-1:0]       r_out_count;

    logic [itoa_pkg::VALUE_W-1:0]     n_work;
    logic [itoa_pkg::DIGIT_W-1:0]     n_rem;
    logic                             w_emit;

    // saturate the written radix into 2..16
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= itoa_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_data < itoa_pkg::BASE_MIN) begin
                r_base <= itoa_pkg::BASE_MIN;
            end else if (i_cfg_data > itoa_pkg::BASE_MAX) begin
                r_base <= itoa_pkg::BASE_MAX;
            end else begin
                r_base <= i_cfg_data;
            end
        end
    end

    // eight restoring steps on the top byte, quotient bits shift in at the bottom
    always_comb begin
        logic [itoa_pkg::DIGIT_W-1:0]  rem;
        logic [itoa_pkg::BASE_W-1:0]   t;
        logic [itoa_pkg::CHUNK_W-1:0]  byte_in;
        logic [itoa_pkg::CHUNK_W-1:0]  qbits;
        rem     = r_rem;
        byte_in = r_work[itoa_pkg::VALUE_W-1 -: itoa_pkg::CHUNK_W];
        qbits   = '0;
        for (int i = itoa_pkg::CHUNK_W - 1; i >= 0; i--) begin
            t = {rem, byte_in[i]};
            if (t >= r_base) begin
                qbits[i] = 1'b1;
                t        = t - r_base;
            end
            rem = t[itoa_pkg::DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = {r_work[itoa_pkg::VALUE_W-itoa_pkg::CHUNK_W-1:0], qbits};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work  <= i_value[itoa_pkg::VALUE_W-1] ?
                       (~i_value + itoa_pkg::VALUE_W'(1)) : i_value;
            r_neg   <= i_value[itoa_pkg::VALUE_W-1];
            r_rem   <= '0;
            r_ndig  <= '0;
            r_nchar <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= n_work;
            if (r_chunk == itoa_pkg::CHUNK_IDX_W'(itoa_pkg::CHUNKS - 1)) begin
                // one division done: push the remainder as the next digit
                r_stack <= {r_stack[itoa_pkg::STACK_W-itoa_pkg::DIGIT_W-1:0], n_rem};
                r_ndig  <= r_ndig + itoa_pkg::CNT_W'(1);
                r_rem   <= '0;
            end else begin
                r_rem <= n_rem;
            end
        end else if (i_cmd.emit_digit) begin
            r_stack <= r_stack >> itoa_pkg::DIGIT_W;
            r_ndig  <= r_ndig - itoa_pkg::CNT_W'(1);
            r_nchar <= r_nchar + itoa_pkg::CNT_W'(1);
        end else if (i_cmd.emit_sign) begin
            r_nchar <= r_nchar + itoa_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.load) begin
            r_chunk <= '0;
        end else if (i_cmd.div_step) begin
            r_chunk <= r_chunk + itoa_pkg::CHUNK_IDX_W'(1);
        end
    end

    assign w_emit = i_cmd.emit_sign | i_cmd.emit_digit | i_cmd.emit_nul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char  <= itoa_pkg::CHAR_MINUS;
            r_out_last  <= 1'b0;
            r_out_count <= '0;
        end else if (i_cmd.emit_digit) begin
            r_out_char  <= itoa_pkg::digit_char(r_stack[itoa_pkg::DIGIT_W-1:0]);
            r_out_last  <= 1'b0;
            r_out_count <= '0;
        end else if (i_cmd.emit_nul) begin
            r_out_char  <= itoa_pkg::CHAR_NUL;
            r_out_last  <= 1'b1;
            r_out_count <= r_nchar;
        end
    end

    assign o_sts.last_chunk = (r_chunk == itoa_pkg::CHUNK_IDX_W'(itoa_pkg::CHUNKS - 1));
    assign o_sts.quot_zero  = (n_work == '0);
    assign o_sts.neg        = r_neg;
    assign o_sts.one_left   = (r_ndig == itoa_pkg::CNT_W'(1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_char      = r_out_char;
    assign o_last      = r_out_last;
    assign o_count     = r_out_count;

endmodule

>>> test/tb_integer_to_ascii_any_base_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_any_base_top
// self-checking bench for the radix-configurable integer to ascii formatter
// ----------------------------------------------------------------------------
// Values are pushed into the slave stream in random bursts while the master
// stream is throttled by its own stall pattern. A scoreboard class predicts
// the character beats of every accepted value in the radix that was in force
// at that moment and compares each outgoing beat field by field. The radix
// register is rewritten between phases, only once all text has drained.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic [itoa_pkg::CNT_W-1:0]  count;
} t_char_beat;

class text_scoreboard;
    logic [itoa_pkg::BASE_W-1:0] radix_reg;
    t_char_beat        pending_chars[$];
    int unsigned       mismatches;
    int unsigned       beats_seen;
    int unsigned       values_seen;
    logic [16:0]       radix_seen;
    string             glyphs;

    function new();
        radix_reg   = itoa_pkg::BASE_RESET;
        mismatches  = 0;
        beats_seen  = 0;
        values_seen = 0;
        radix_seen  = '0;
        glyphs      = "0123456789ABCDEF";
    endfunction

    // expected text of one accepted value, pushed onto the pending queue
    function void note_value(logic [itoa_pkg::VALUE_W-1:0] raw);
        logic              neg;
        logic [itoa_pkg::VALUE_W-1:0] mag;
        int unsigned       radix;
        int unsigned       n;
        byte unsigned      digits[$];
        t_char_beat        b;
        neg = raw[itoa_pkg::VALUE_W-1];
        mag = neg ? (~raw + itoa_pkg::VALUE_W'(1)) : raw;
        if (radix_reg < itoa_pkg::BASE_MIN) begin
            radix = itoa_pkg::BASE_MIN;
        end else if (radix_reg > itoa_pkg::BASE_MAX) begin
            radix = itoa_pkg::BASE_MAX;
        end else begin
            radix = radix_reg;
        end
        radix_seen[radix] = 1'b1;
        do begin
            digits.push_front(glyphs.getc(int'(mag % radix)));
            mag = mag / radix;
        end while (mag != 0);
        n = 0;
        if (neg) begin
            b = '{ch: itoa_pkg::CHAR_MINUS, last: 1'b0, count: '0};
            pending_chars.push_back(b);
            n++;
        end
        foreach (digits[i]) begin
            b = '{ch: digits[i], last: 1'b0, count: '0};
            pending_chars.push_back(b);
            n++;
        end
        b = '{ch: itoa_pkg::CHAR_NUL, last: 1'b1, count: n[itoa_pkg::CNT_W-1:0]};
        pending_chars.push_back(b);
        values_seen++;
    endfunction

    // one outgoing beat against the oldest pending character
    function void check_beat(logic [itoa_pkg::OUT_DATA_W-1:0] data, logic last);
        t_char_beat want;
        beats_seen++;
        if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat %0d: char %h last %b count %0d",
                         beats_seen, data[7:0], last, data[13:8]);
            return;
        end
        want = pending_chars.pop_front();
        if (data[7:0] !== want.ch || last !== want.last ||
            data[13:8] !== want.count || data[15:14] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"beat %0d: expected char %h last %b count %0d, ",
                          "got char %h last %b count %0d pad %b"},
                         beats_seen, want.ch, want.last, want.count,
                         data[7:0], last, data[13:8], data[15:14]);
        end
    endfunction
endclass

module tb_integer_to_ascii_any_base_top;

    // generous ceiling: ~450 values, each with at most 32 digit divisions
    // plus 34 beats under heavy stalls, fit well inside it
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 420;
    // one value in flight, longest run for base 2
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [7:0] char_out, [13:8] char_count, [15:14] zero
    logic        m_axis_tlast;          // is_last

    text_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned radix_writes = 0;

    integer_to_ascii_any_base_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycles, sb.pending_chars.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // output monitor: every accepted character beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
    end

    // sink throttle: stretches of always-ready, light random stalls,
    // a fixed periodic hole and heavy back-pressure
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;
    int unsigned rx_period = 3;
    int unsigned rx_phase = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(3, 0);
            rx_left   = $urandom_range(200, 20);
            rx_period = $urandom_range(5, 2);
        end
        rx_left  = rx_left - 1;
        rx_phase = (rx_phase + 1) % rx_period;
        case (rx_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(3, 0) != 0);
            end
            2: begin
                m_axis_tready <= (rx_phase != 0);
            end
            default: begin
                m_axis_tready <= ($urandom_range(3, 0) == 0);
            end
        endcase
    end

    // wait until every predicted character has left the block
    task automatic drain_text();
        // drop the last value beat so it is not taken a second time
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // radix write, only with the block idle
    task automatic write_radix(logic [4:0] radix);
        drain_text();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        i_cfg_valid   <= 1'b1;
        i_cfg_data    <= radix;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        sb.radix_reg = radix;
        radix_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        // the next burst starts fresh after the write
        burst_left = 0;
    endtask

    // one value beat, with a random gap between bursts
    task automatic send_value(logic [31:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_value(value);
        burst_left--;
    endtask

    // random value: full-range words, small magnitudes of both signs,
    // values around the extremes and shifted words of random length
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(5, 0))
            0, 1: v = $urandom();
            2: v = $urandom_range(255, 0);
            3: v = -$urandom_range(256, 1);
            4: v = ($urandom_range(1, 0) != 0) ? 32'h7FFF_FFFF - $urandom_range(15, 0)
                                               : 32'h8000_0000 + $urandom_range(15, 0);
            default: begin
                v = $urandom() >> $urandom_range(31, 0);
                if ($urandom_range(1, 0) != 0)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial begin
        int unsigned sent_random;
        int unsigned phase_len;
        logic [4:0]  radix;

        sent_random = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset radix of ten first
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);

        // register value zero clamps to base two; most negative is the longest run
        write_radix(5'd0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);
        // register value one clamps to base two as well
        write_radix(5'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd5);
        write_radix(5'd2);
        send_value(32'hAAAA_AAAA);
        send_value(32'd3);
        write_radix(5'd16);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'hDEAD_BEEF);
        send_value(32'd0);
        // above sixteen clamps to sixteen
        write_radix(5'd17);
        send_value(32'd255);
        send_value(32'h8000_0000);
        write_radix(5'd31);
        send_value(32'h0123_ABCD);
        write_radix(5'd3);
        send_value(32'h8000_0000);
        send_value(32'd7);

        // random phases, each with its own radix; out-of-range register
        // values show up now and then to exercise the clamping
        while (sent_random < RANDOM_ITEMS) begin
            if ($urandom_range(3, 0) == 0)
                radix = $urandom_range(31, 0);
            else
                radix = $urandom_range(16, 2);
            write_radix(radix);
            phase_len = $urandom_range(50, 25);
            repeat (phase_len) begin
                send_value(random_value());
                sent_random++;
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("formatted %0d values through %0d radix writes (bases hit mask %b)",
                 sb.values_seen, radix_writes, sb.radix_seen[16:2]);
        $display("checked %0d character beats, %0d mismatches",
                 sb.beats_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
